// File: hdl/lru_tag_store_with_invalidate_macros.svh
// Assertion macros for the LRU tag store.
`ifndef LRU_TAG_STORE_WITH_INVALIDATE_MACROS_SVH
`define LRU_TAG_STORE_WITH_INVALIDATE_MACROS_SVH
`ifndef SYNTH
// Hold expr at every clock edge out of reset.
`define LTS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// When ante holds, cons holds in the same cycle.
`define LTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// When ante holds, cons holds in the next cycle.
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LTS_ASSERT_ALWAYS(lbl, expr, msg)
`define LTS_ASSERT_SAME(lbl, ante, cons, msg)
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/lts_pkg.sv
// Shared types and constants of the LRU tag store.
`timescale 1ns / 1ps
package lts_pkg;

    localparam int ENTRIES_DEF = 128;
    localparam int OP_W        = 2;
    localparam int FONT_W      = 8;
    localparam int TEXT_W      = 32;
    localparam int COLOR_W     = 32;
    localparam int STAMP_W     = 32;
    localparam int SLOT_W      = 7;

    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd0;
    localparam logic [OP_W-1:0] OP_INV_FONT = 2'd1;
    localparam logic [OP_W-1:0] OP_INV_TEXT = 2'd2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // One stored slot.
    typedef struct packed {
        logic               valid;
        logic [FONT_W-1:0]  font;
        logic [TEXT_W-1:0]  text;
        logic [COLOR_W-1:0] color;
        logic [STAMP_W-1:0] stamp;
    } lts_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_step;
        logic finish;
    } lts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ctr_last;
    } lts_stat_t;

endpackage

// File: hdl/lts_dpath.sv
// Datapath of the LRU tag store: slot memory, scan counter, victim search, outputs.
`timescale 1ns / 1ps
module lts_dpath
    import lts_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lts_cmd_t           cmd,
    output lts_stat_t          stat,
    input  logic [OP_W-1:0]    op,
    input  logic [FONT_W-1:0]  font_id,
    input  logic [TEXT_W-1:0]  text_key,
    input  logic [COLOR_W-1:0] color,
    output logic               done,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot,
    output logic               evicted
);

    localparam int IDX_W = $clog2(ENTRIES);

    lts_entry_t         mem [ENTRIES];
    lts_entry_t         rd_data_reg;

    logic [OP_W-1:0]    op_reg;
    logic [FONT_W-1:0]  font_reg;
    logic [TEXT_W-1:0]  text_reg;
    logic [COLOR_W-1:0] color_reg;

    logic [IDX_W-1:0]   ctr_reg;
    logic               eval_vld_reg;
    logic [IDX_W-1:0]   eval_idx_reg;

    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               have_free_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               have_old_reg;
    logic [IDX_W-1:0]   old_idx_reg;
    logic [STAMP_W-1:0] old_stamp_reg;
    logic [STAMP_W-1:0] stamp_cnt_reg;

    logic               done_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               evicted_reg;

    logic               ctr_last;
    logic               font_eq;
    logic               text_eq;
    logic               color_eq;
    logic               lk_match;
    logic               inv_match;
    logic               is_lookup;
    logic [IDX_W-1:0]   sel_idx;
    logic [STAMP_W-1:0] fresh_stamp;
    logic [IDX_W+SLOT_W-1:0] slot_wide;
    logic               we;
    logic [IDX_W-1:0]   wa;
    lts_entry_t         wd;

    assign ctr_last  = (ctr_reg == IDX_W'(ENTRIES - 1));
    assign stat      = '{ctr_last: ctr_last};

    assign font_eq   = (rd_data_reg.font == font_reg);
    assign text_eq   = (rd_data_reg.text == text_reg);
    assign color_eq  = (rd_data_reg.color == color_reg);
    assign lk_match  = eval_vld_reg && rd_data_reg.valid && font_eq && text_eq && color_eq;
    assign inv_match = eval_vld_reg && rd_data_reg.valid && font_eq &&
                       ((op_reg == OP_INV_FONT) || ((op_reg == OP_INV_TEXT) && text_eq));
    assign is_lookup = (op_reg == OP_LOOKUP);

    assign sel_idx     = found_reg ? hit_idx_reg : (have_free_reg ? free_idx_reg : old_idx_reg);
    assign fresh_stamp = (stamp_cnt_reg == STAMP_MAX) ? stamp_cnt_reg
                                                      : stamp_cnt_reg + STAMP_W'(1);
    assign slot_wide   = {{SLOT_W{1'b0}}, sel_idx};

    // Single write port: clearing pass, invalidate write-back, or lookup commit.
    always_comb
    begin
        we = 1'b0;
        wa = ctr_reg;
        wd = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (cmd.finish && is_lookup)
        begin
            we = 1'b1;
            wa = sel_idx;
            wd = '{valid: 1'b1, font: font_reg, text: text_reg, color: color_reg,
                   stamp: fresh_stamp};
        end
        else if (inv_match)
        begin
            we       = 1'b1;
            wa       = eval_idx_reg;
            wd       = rd_data_reg;
            wd.valid = 1'b0;
            if (op_reg == OP_INV_TEXT)
            begin
                wd.stamp = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_step)
        begin
            rd_data_reg  <= mem[ctr_reg];
            eval_idx_reg <= ctr_reg;
        end
        if (cmd.load)
        begin
            op_reg    <= op;
            font_reg  <= font_id;
            text_reg  <= text_key;
            color_reg <= color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            have_free_reg <= 1'b0;
            free_idx_reg  <= '0;
            have_old_reg  <= 1'b0;
            old_idx_reg   <= '0;
            old_stamp_reg <= '0;
            stamp_cnt_reg <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            slot_reg      <= '0;
            evicted_reg   <= 1'b0;
        end
        else
        begin
            eval_vld_reg <= cmd.rd_step;

            if (cmd.load)
            begin
                ctr_reg <= '0;
            end
            else if (cmd.clr_step || cmd.rd_step)
            begin
                ctr_reg <= ctr_last ? '0 : ctr_reg + IDX_W'(1);
            end

            // First match wins; otherwise track first free and oldest valid slot.
            if (cmd.load)
            begin
                found_reg     <= 1'b0;
                have_free_reg <= 1'b0;
                have_old_reg  <= 1'b0;
            end
            else if (eval_vld_reg && !found_reg)
            begin
                if (lk_match)
                begin
                    found_reg   <= 1'b1;
                    hit_idx_reg <= eval_idx_reg;
                end
                else if (!rd_data_reg.valid)
                begin
                    if (!have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                        free_idx_reg  <= eval_idx_reg;
                    end
                end
                else if (!have_old_reg || (rd_data_reg.stamp < old_stamp_reg))
                begin
                    have_old_reg  <= 1'b1;
                    old_idx_reg   <= eval_idx_reg;
                    old_stamp_reg <= rd_data_reg.stamp;
                end
            end

            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                hit_reg     <= is_lookup && found_reg;
                slot_reg    <= is_lookup ? slot_wide[SLOT_W-1:0] : '0;
                evicted_reg <= is_lookup && !found_reg && !have_free_reg;
                if (is_lookup)
                begin
                    stamp_cnt_reg <= fresh_stamp;
                end
            end
        end
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign slot    = slot_reg;
    assign evicted = evicted_reg;

endmodule

// File: hdl/lts_ctrl.sv
// Controller of the LRU tag store: clearing pass, scan sequencing and commit.
`timescale 1ns / 1ps
module lts_ctrl
    import lts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  lts_stat_t stat,
    output lts_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.ctr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_step = 1'b1;
                if (stat.ctr_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: hdl/lru_tag_store_with_invalidate.sv
// Top level of the fully associative LRU tag store with invalidation.
`timescale 1ns / 1ps
`include "lru_tag_store_with_invalidate_macros.svh"
// Fully associative tag store of ENTRIES slots, each holding font, text key,
// colour and a use stamp in one on-chip memory. Issue an item by raising start
// while busy is low; the item is taken at that edge. Every item, lookup or
// invalidate, walks all slots through the single memory read port, one slot per
// cycle, and a new item may be issued in the very cycle that done is high. The
// result shows on hit, slot and evicted for exactly one cycle with done high; the
// receiver cannot stall it, so capture it then. After reset the block runs a
// clearing pass that drops every slot's valid flag; busy stays high until it is
// finished. slot carries the low seven bits of the slot index and is zero for
// invalidations. Lookups refresh the stamp of a hit, or fill the first free
// slot, else evict the oldest stamp with the lowest index winning ties.
module lru_tag_store_with_invalidate
    import lts_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [FONT_W-1:0]  font_id,
    input  logic [TEXT_W-1:0]  text_key,
    input  logic [COLOR_W-1:0] color,
    output logic               done,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot,
    output logic               evicted
);

    lts_cmd_t  cmd;
    lts_stat_t stat;

    // Sequence the clearing pass, the slot scan and the final commit.
    lts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Hold the slots, compare each against the item and drive the result.
    lts_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .op       (op),
        .font_id  (font_id),
        .text_key (text_key),
        .color    (color),
        .done     (done),
        .hit      (hit),
        .slot     (slot),
        .evicted  (evicted)
    );

    // A result comes out only once the controller is back to idle.
    `LTS_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
    // An accepted item always starts a scan.
    `LTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
    // A result lasts one cycle only.
    `LTS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held over two cycles")
    // An eviction happens only on a miss.
    `LTS_ASSERT_ALWAYS(a_evict_miss, !(hit && evicted), "eviction reported on a hit")

endmodule

// File: test/tb_lru_tag_store_with_invalidate.sv
// Self-checking testbench for the LRU tag store with font and text invalidation.
`timescale 1ns / 1ps
module tb_lru_tag_store_with_invalidate;
    import lts_pkg::*;

    localparam int N_SLOTS         = ENTRIES_DEF;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 132;
    localparam int N_PHASES        = 4;
    localparam int FONT_POOL_SIZE  = 32;
    localparam int KEY_LOG_DEPTH   = 256;
    localparam int REPORT_LIMIT    = 10;

    // The op encoding leaves one code unused; the block must treat it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One result item as it appears on hit, slot and evicted.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } tag_result_t;

    // The key part of a lookup, kept so that later items can hit or invalidate it.
    typedef struct packed {
        logic [FONT_W-1:0]  font;
        logic [TEXT_W-1:0]  text;
        logic [COLOR_W-1:0] color;
    } cache_key_t;

    // One row of the directed table. Where known_result is set, the result is
    // written into the row; otherwise the shadow store supplies it.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FONT_W-1:0]  font;
        logic [TEXT_W-1:0]  text;
        logic [COLOR_W-1:0] color;
        logic               known_result;
        tag_result_t        result;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    op;
    logic [FONT_W-1:0]  font_id;
    logic [TEXT_W-1:0]  text_key;
    logic [COLOR_W-1:0] color;
    logic               done;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;

    // Shadow copy of the tag store, advanced once per accepted item.
    logic               shadow_valid [N_SLOTS];
    logic [FONT_W-1:0]  shadow_font  [N_SLOTS];
    logic [TEXT_W-1:0]  shadow_text  [N_SLOTS];
    logic [COLOR_W-1:0] shadow_color [N_SLOTS];
    logic [STAMP_W-1:0] shadow_stamp [N_SLOTS];
    logic [STAMP_W-1:0] shadow_stamp_ctr;

    tag_result_t   pending_results [$];
    directed_row_t directed_rows [$];
    cache_key_t    key_log [$];
    logic [FONT_W-1:0] font_pool [FONT_POOL_SIZE];

    int mismatch_count = 0;
    int cycle_count    = 0;

    lru_tag_store_with_invalidate i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .font_id  (font_id),
        .text_key (text_key),
        .color    (color),
        .done     (done),
        .hit      (hit),
        .slot     (slot),
        .evicted  (evicted)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one item to the shadow store and return the result it must give.
    // A lookup scans every slot: stop at the first valid match, otherwise note
    // the first free slot and the valid slot with the lowest stamp (strict
    // less-than, so the lowest index wins a tie).
    function automatic tag_result_t apply_to_store(input logic [OP_W-1:0]    op_i,
                                                   input logic [FONT_W-1:0]  font_i,
                                                   input logic [TEXT_W-1:0]  text_i,
                                                   input logic [COLOR_W-1:0] color_i);
        tag_result_t        res;
        bit                 found;
        bit                 have_free;
        bit                 have_old;
        int                 hit_idx;
        int                 free_idx;
        int                 old_idx;
        int                 target;
        logic [STAMP_W-1:0] old_stamp;
        res       = '0;
        found     = 1'b0;
        have_free = 1'b0;
        have_old  = 1'b0;
        hit_idx   = 0;
        free_idx  = 0;
        old_idx   = 0;
        old_stamp = STAMP_MAX;
        case (op_i)
            OP_LOOKUP:
            begin
                for (int i = 0; i < N_SLOTS && !found; i++)
                begin
                    if (shadow_valid[i] && shadow_font[i] == font_i &&
                        shadow_text[i] == text_i && shadow_color[i] == color_i)
                    begin
                        found   = 1'b1;
                        hit_idx = i;
                    end
                    else if (!shadow_valid[i])
                    begin
                        if (!have_free)
                        begin
                            have_free = 1'b1;
                            free_idx  = i;
                        end
                    end
                    else if (!have_old || shadow_stamp[i] < old_stamp)
                    begin
                        have_old  = 1'b1;
                        old_stamp = shadow_stamp[i];
                        old_idx   = i;
                    end
                end
                if (found)
                begin
                    res.hit = 1'b1;
                    target  = hit_idx;
                end
                else
                begin
                    target      = have_free ? free_idx : old_idx;
                    res.evicted = !have_free;
                    shadow_valid[target] = 1'b1;
                    shadow_font[target]  = font_i;
                    shadow_text[target]  = text_i;
                    shadow_color[target] = color_i;
                end
                // Hit and fill both take a fresh stamp; the counter sticks at its top.
                if (shadow_stamp_ctr != STAMP_MAX)
                    shadow_stamp_ctr = shadow_stamp_ctr + 1'b1;
                shadow_stamp[target] = shadow_stamp_ctr;
                res.slot = target[SLOT_W-1:0];
            end
            OP_INV_FONT:
            begin
                // Drop validity only; stamps stay as they were.
                for (int i = 0; i < N_SLOTS; i++)
                    if (shadow_valid[i] && shadow_font[i] == font_i)
                        shadow_valid[i] = 1'b0;
            end
            OP_INV_TEXT:
            begin
                // Colour plays no part here; clear the stamp as well.
                for (int i = 0; i < N_SLOTS; i++)
                    if (shadow_valid[i] && shadow_font[i] == font_i && shadow_text[i] == text_i)
                    begin
                        shadow_valid[i] = 1'b0;
                        shadow_stamp[i] = '0;
                    end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] o, input logic [FONT_W-1:0] f,
                           input logic [TEXT_W-1:0] t, input logic [COLOR_W-1:0] c,
                           input int known, input int h, input int s, input int e);
        directed_row_t row;
        row.op           = o;
        row.font         = f;
        row.text         = t;
        row.color        = c;
        row.known_result = known[0];
        row.result.hit     = h[0];
        row.result.slot    = s[SLOT_W-1:0];
        row.result.evicted = e[0];
        directed_rows.push_back(row);
    endtask

    // Present an item and hold it until the block takes it, then queue the
    // result it must produce. start is left high so a following item can go
    // out back to back.
    task automatic issue_item(input logic [OP_W-1:0] o, input logic [FONT_W-1:0] f,
                              input logic [TEXT_W-1:0] t, input logic [COLOR_W-1:0] c,
                              input logic known, input tag_result_t known_res);
        tag_result_t predicted;
        start    <= 1'b1;
        op       <= o;
        font_id  <= f;
        text_key <= t;
        color    <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = apply_to_store(o, f, t, c);
        pending_results.push_back(known ? known_res : predicted);
    endtask

    // Hold start low for a random number of cycles. Most gaps are short runs
    // drawn per cycle; now and then a long one drops the next item at some
    // arbitrary point of the block's slot walk.
    task automatic sender_gap(input int idle_pct);
        int n;
        n = 0;
        if (idle_pct > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, N_SLOTS + 12);
            else
                while ($urandom_range(0, 99) < idle_pct)
                    n++;
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Draw one random item. The first phase is mostly fresh lookups so the
    // store fills and starts evicting; later phases mix re-lookups of logged
    // keys (hits), fresh keys (fills and evictions) and invalidations aimed
    // at logged keys.
    task automatic pick_item(input int phase_i, output logic [OP_W-1:0] o,
                             output logic [FONT_W-1:0] f, output logic [TEXT_W-1:0] t,
                             output logic [COLOR_W-1:0] c);
        int         roll;
        int         fresh_pct;
        int         again_pct;
        cache_key_t k;
        roll      = $urandom_range(0, 99);
        fresh_pct = (phase_i == 0) ? 95 : 35;
        again_pct = (phase_i == 0) ? 97 : 88;
        o = OP_LOOKUP;
        f = font_pool[$urandom_range(0, FONT_POOL_SIZE - 1)];
        t = $urandom;
        c = $urandom;
        k = '0;
        if (key_log.size() != 0)
            k = key_log[$urandom_range(0, key_log.size() - 1)];
        if (roll < fresh_pct || key_log.size() == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                f = FONT_W'($urandom_range(0, 255));
            // Sometimes reuse font and text with a new colour: a near miss.
            if (key_log.size() != 0 && $urandom_range(0, 4) == 0)
            begin
                f = k.font;
                t = k.text;
            end
            key_log.push_back('{font: f, text: t, color: c});
            if (key_log.size() > KEY_LOG_DEPTH)
                void'(key_log.pop_front());
        end
        else if (roll < again_pct)
        begin
            f = k.font;
            t = k.text;
            c = k.color;
        end
        else if (roll < again_pct + 6 - (phase_i == 0 ? 5 : 0))
        begin
            o = OP_INV_TEXT;
            f = k.font;
            t = k.text;
        end
        else if (roll < 98)
        begin
            o = OP_INV_FONT;
            f = k.font;
        end
        else
        begin
            o = OP_UNUSED;
            f = FONT_W'($urandom_range(0, 255));
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // Results come out for one cycle with done high and cannot be held off,
    // so take each one at the edge that ends that cycle.
    always @(posedge clk)
    begin : result_check
        tag_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result item with nothing outstanding: hit %0b slot %0d",
                             $realtime, hit, slot);
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("hit", 32'(want.hit), 32'(hit));
                report_field("slot", 32'(want.slot), 32'(slot));
                report_field("evicted", 32'(want.evicted), 32'(evicted));
            end
        end
    end

    // Guard against a hung block; the limit sits well above the slowest run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [OP_W-1:0]    r_op;
        logic [FONT_W-1:0]  r_font;
        logic [TEXT_W-1:0]  r_text;
        logic [COLOR_W-1:0] r_color;
        int                 idle_pct;
        // Hold every input at a known value from time zero.
        rst_n    <= 1'b0;
        start    <= 1'b0;
        op       <= OP_LOOKUP;
        font_id  <= '0;
        text_key <= '0;
        color    <= '0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_font[i]  = '0;
            shadow_text[i]  = '0;
            shadow_color[i] = '0;
            shadow_stamp[i] = '0;
        end
        shadow_stamp_ctr = '0;
        for (int i = 0; i < FONT_POOL_SIZE; i++)
            font_pool[i] = FONT_W'($urandom_range(0, 255));

        // Directed table. Rows with a written result follow the slot walk by
        // hand from an empty store; the rest lean on the shadow store.
        //       op           font   text          color         known hit slot ev
        add_row(OP_LOOKUP,   8'h00, 32'h00000000, 32'h00000000, 1, 0, 0, 0); // empty store: fill slot 0
        add_row(OP_LOOKUP,   8'h00, 32'h00000000, 32'h00000000, 1, 1, 0, 0); // same key hits
        add_row(OP_LOOKUP,   8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 1, 0); // all ones
        add_row(OP_LOOKUP,   8'hFF, 32'hFFFFFFFF, 32'h00000000, 1, 0, 2, 0); // colour alone differs
        add_row(OP_LOOKUP,   8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 1, 0);
        add_row(OP_INV_TEXT, 8'hFF, 32'hFFFFFFFF, 32'h12345678, 1, 0, 0, 0); // drops slots 1 and 2
        add_row(OP_LOOKUP,   8'hFF, 32'hFFFFFFFF, 32'h00000000, 1, 0, 1, 0); // first free slot
        add_row(OP_UNUSED,   8'hFF, 32'hFFFFFFFF, 32'h00000000, 1, 0, 0, 0); // unused op: no change
        add_row(OP_LOOKUP,   8'hFF, 32'hFFFFFFFF, 32'h00000000, 1, 1, 1, 0);
        add_row(OP_INV_FONT, 8'h00, 32'hDEADBEEF, 32'h00000000, 1, 0, 0, 0); // drops slot 0
        add_row(OP_LOOKUP,   8'h00, 32'h00000000, 32'h00000000, 1, 0, 0, 0);
        add_row(OP_INV_FONT, 8'h55, 32'h00000000, 32'h00000000, 1, 0, 0, 0); // matches nothing
        add_row(OP_INV_TEXT, 8'hFF, 32'h00000000, 32'h00000000, 1, 0, 0, 0); // matches nothing
        add_row(OP_LOOKUP,   8'hFF, 32'hFFFFFFFF, 32'h00000000, 1, 1, 1, 0);
        add_row(OP_LOOKUP,   8'hA5, 32'h5A5A5A5A, 32'h80FF00FF, 1, 0, 2, 0);
        add_row(OP_LOOKUP,   8'h5A, 32'hA5A5A5A5, 32'h7F00FF00, 0, 0, 0, 0);
        add_row(OP_LOOKUP,   8'hA5, 32'h5A5A5A5A, 32'h80FF00FE, 0, 0, 0, 0); // one colour bit off
        add_row(OP_INV_FONT, 8'hFF, 32'h00000000, 32'h00000000, 1, 0, 0, 0);
        add_row(OP_LOOKUP,   8'h01, 32'h00000001, 32'h00000001, 0, 0, 0, 0);
        add_row(OP_INV_TEXT, 8'hA5, 32'h5A5A5A5A, 32'h00000000, 1, 0, 0, 0); // both colours go
        add_row(OP_LOOKUP,   8'hA5, 32'h5A5A5A5A, 32'h80FF00FF, 0, 0, 0, 0);
        add_row(OP_UNUSED,   8'h00, 32'h00000000, 32'h00000000, 1, 0, 0, 0);
        add_row(OP_LOOKUP,   8'h80, 32'h80000000, 32'h80000000, 0, 0, 0, 0);

        // Release reset once; the block then runs its clearing pass with busy
        // high, which the handshake below simply waits out.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_item(directed_rows[i].op, directed_rows[i].font, directed_rows[i].text,
                       directed_rows[i].color, directed_rows[i].known_result,
                       directed_rows[i].result);

        // Random phases: back to back, sender mostly idle, sender idle now and
        // then, back to back again. Drain at each phase boundary and at random.
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            idle_pct = (phase == 1) ? 78 : (phase == 2) ? 22 : 0;
            drain_results();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 29) == 0)
                    drain_results();
                else
                    sender_gap(idle_pct);
                pick_item(phase, r_op, r_font, r_text, r_color);
                issue_item(r_op, r_font, r_text, r_color, 1'b0, '0);
            end
        end

        // Wait for the last results, then allow one more slot walk for strays.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (N_SLOTS + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lts_pkg.sv
hdl/lts_dpath.sv
hdl/lts_ctrl.sv
hdl/lru_tag_store_with_invalidate.sv
test/tb_lru_tag_store_with_invalidate.sv
